// ===== src/cov_pkg.sv =====
// Shared types, constants and lookup functions for the capsule outline vertex core.
// Used by cov_vec_cell, cov_rot_cell and capsule_outline_vertex_core; no dependencies.
package cov_pkg;

    localparam int CAP_VERTICES  = 15;
    localparam int FRACTION_BITS = 4;
    localparam int CORDIC_STEPS  = 16;
    localparam int STEP_W        = 4;
    localparam int IDX_W         = 5;
    localparam int K_W           = 4;
    localparam int LAST_INDEX    = 2 * CAP_VERTICES - 1;

    localparam int COORD_W = 16;
    localparam int WIDTH_W = 15;
    localparam int XY_W    = 34;
    localparam int ANG_W   = 32;
    localparam int RZ_W    = 34;
    localparam int PROD_W  = 31;
    localparam int RND_W   = 17;
    localparam int SUM_W   = 19;

    localparam int INV_GAIN    = 39797;
    localparam int PRESCALE_SH = 14;
    localparam int OUT_SHIFT   = 17;
    localparam int ONE         = 1 << FRACTION_BITS;

    localparam logic [ANG_W-1:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [ANG_W-1:0] QUARTER_TURN = 32'h4000_0000;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_DX     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_DY     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 2'd2;

    localparam logic [WIDTH_W-1:0] LINE_WIDTH_RST = 15'd16;

    typedef struct packed {
        logic           end_cap;
        logic [K_W-1:0] k;
        logic           zero;
    } t_side;

    // atan(2^-i) in binary angle units, 2^32 per turn
    function automatic logic [ANG_W-1:0] atan_lut(input logic [STEP_W-1:0] step);
        logic [ANG_W-1:0] v;
        case (step)
            4'd0:    v = 32'h2000_0000;
            4'd1:    v = 32'h12E4_051E;
            4'd2:    v = 32'h09FB_385B;
            4'd3:    v = 32'h0511_11D4;
            4'd4:    v = 32'h028B_0D43;
            4'd5:    v = 32'h0145_D7E1;
            4'd6:    v = 32'h00A2_F61E;
            4'd7:    v = 32'h0051_7C55;
            4'd8:    v = 32'h0028_BE53;
            4'd9:    v = 32'h0014_5F2F;
            4'd10:   v = 32'h000A_2F98;
            4'd11:   v = 32'h0005_17CC;
            4'd12:   v = 32'h0002_8BE6;
            4'd13:   v = 32'h0001_45F3;
            4'd14:   v = 32'h0000_A2FA;
            default: v = 32'h0000_517D;
        endcase
        return v;
    endfunction

    // floor(k * 2^31 / (CAP_VERTICES-1)), the cap angle step for vertex k
    function automatic logic [ANG_W-1:0] cap_step(input logic [K_W-1:0] k);
        logic [ANG_W-1:0] v;
        case (k)
            4'd0:    v = 32'd0;
            4'd1:    v = 32'd153391689;
            4'd2:    v = 32'd306783378;
            4'd3:    v = 32'd460175067;
            4'd4:    v = 32'd613566756;
            4'd5:    v = 32'd766958445;
            4'd6:    v = 32'd920350134;
            4'd7:    v = 32'd1073741824;
            4'd8:    v = 32'd1227133513;
            4'd9:    v = 32'd1380525202;
            4'd10:   v = 32'd1533916891;
            4'd11:   v = 32'd1687308580;
            4'd12:   v = 32'd1840700269;
            4'd13:   v = 32'd1994091958;
            default: v = 32'd2147483648;
        endcase
        return v;
    endfunction

    function automatic logic signed [COORD_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > SUM_W'(32767))
            r = 16'sh7FFF;
        else if (v < -SUM_W'(32768))
            r = 16'sh8000;
        else
            r = COORD_W'(v);
        return r;
    endfunction

endpackage

// ===== src/cov_vec_cell.sv =====
// One vectoring CORDIC cell: turns (x, y) toward the x axis and accumulates the angle.
// Depends on cov_pkg.
module cov_vec_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic [cov_pkg::STEP_W-1:0]         i_step,
    input  logic                               i_valid,
    input  logic signed [cov_pkg::XY_W-1:0]    i_x,
    input  logic signed [cov_pkg::XY_W-1:0]    i_y,
    input  logic [cov_pkg::ANG_W-1:0]          i_z,
    input  cov_pkg::t_side                     i_side,
    output logic                               o_valid,
    output logic signed [cov_pkg::XY_W-1:0]    o_x,
    output logic signed [cov_pkg::XY_W-1:0]    o_y,
    output logic [cov_pkg::ANG_W-1:0]          o_z,
    output cov_pkg::t_side                     o_side
);

    logic signed [cov_pkg::XY_W-1:0] xs, ys, n_x, n_y;
    logic [cov_pkg::ANG_W-1:0]       n_z;
    logic                            r_valid;
    logic signed [cov_pkg::XY_W-1:0] r_x, r_y;
    logic [cov_pkg::ANG_W-1:0]       r_z;
    cov_pkg::t_side                  r_side;

    always_comb begin
        xs = i_x >>> i_step;
        ys = i_y >>> i_step;
        if (i_y > 0) begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + cov_pkg::atan_lut(i_step);
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - cov_pkg::atan_lut(i_step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule

// ===== src/cov_rot_cell.sv =====
// One rotation CORDIC cell: rotates (x, y) by +/- atan(2^-step) toward the residual angle.
// Depends on cov_pkg.
module cov_rot_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic [cov_pkg::STEP_W-1:0]         i_step,
    input  logic                               i_valid,
    input  logic signed [cov_pkg::XY_W-1:0]    i_x,
    input  logic signed [cov_pkg::XY_W-1:0]    i_y,
    input  logic signed [cov_pkg::RZ_W-1:0]    i_z,
    input  cov_pkg::t_side                     i_side,
    output logic                               o_valid,
    output logic signed [cov_pkg::XY_W-1:0]    o_x,
    output logic signed [cov_pkg::XY_W-1:0]    o_y,
    output logic signed [cov_pkg::RZ_W-1:0]    o_z,
    output cov_pkg::t_side                     o_side
);

    logic signed [cov_pkg::XY_W-1:0] xs, ys, n_x, n_y;
    logic signed [cov_pkg::RZ_W-1:0] n_z, atan_z;
    logic                            r_valid;
    logic signed [cov_pkg::XY_W-1:0] r_x, r_y;
    logic signed [cov_pkg::RZ_W-1:0] r_z;
    cov_pkg::t_side                  r_side;

    always_comb begin
        xs     = i_x >>> i_step;
        ys     = i_y >>> i_step;
        atan_z = cov_pkg::RZ_W'(cov_pkg::atan_lut(i_step));
        if (!i_z[cov_pkg::RZ_W-1]) begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - atan_z;
        end else begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + atan_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule

// ===== src/capsule_outline_vertex_core.sv =====
// Top level of the capsule outline vertex generator.
// Depends on cov_pkg, cov_vec_cell and cov_rot_cell.
//
// Usage:
//   Write end_dx (index 0), end_dy (index 1) and line_width (index 2) through the
//   i_cfg_* port while no item is in flight. Then send vertex indices on the
//   i_valid/o_ready input channel; each index returns one (x, y) vertex on the
//   o_valid/i_ready output channel, in order. Indices 0..14 lie on the end cap,
//   15..29 on the start cap; larger indices act as 29.
// Pipeline: input stage, 16 vectoring cells, angle/scale stage, 16 rotation cells,
//   rounding stage, output register.
// Throughput: one item per cycle while the chain is not held by a stall; each CORDIC
//   cell handles one iteration for one item and passes it on whenever the chain advances.
// Stall: the output register is backed by a one-entry skid register. While the
//   receiver stalls, the chain keeps advancing until the skid entry fills; then
//   the whole chain and o_ready hold until the receiver takes an item.
// Reset: i_rst_n (synchronous, active low) drops all items in flight, clears
//   end_dx and end_dy to 0 and sets line_width to 1.0 pixel.
module capsule_outline_vertex_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_wen,
    input  logic [cov_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [cov_pkg::COORD_W-1:0]            i_cfg_wdata,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [cov_pkg::IDX_W-1:0]              i_vertex_index,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [cov_pkg::COORD_W-1:0]     o_vertex_x,
    output logic signed [cov_pkg::COORD_W-1:0]     o_vertex_y
);

    localparam int NS = cov_pkg::CORDIC_STEPS;

    // Configuration registers
    logic signed [cov_pkg::COORD_W-1:0] r_end_dx, r_end_dy;
    logic [cov_pkg::WIDTH_W-1:0]        r_line_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_dx     <= '0;
            r_end_dy     <= '0;
            r_line_width <= cov_pkg::LINE_WIDTH_RST;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                cov_pkg::CFG_END_DX:     r_end_dx     <= i_cfg_wdata;
                cov_pkg::CFG_END_DY:     r_end_dy     <= i_cfg_wdata;
                cov_pkg::CFG_LINE_WIDTH: r_line_width <= i_cfg_wdata[cov_pkg::WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    // Chain advance: hold everything once the skid entry is occupied
    logic en;
    logic r_skid_valid;

    assign en      = !r_skid_valid;
    assign o_ready = en;

    // Input stage: clamp the index, split cap/vertex, pre-scale and fold the vector
    logic [cov_pkg::IDX_W-1:0]       idx_c;
    cov_pkg::t_side                  n_s0_side;
    logic signed [cov_pkg::XY_W-1:0] n_s0_x, n_s0_y;
    logic [cov_pkg::ANG_W-1:0]       n_s0_z;

    logic                            r_s0_valid;
    logic signed [cov_pkg::XY_W-1:0] r_s0_x, r_s0_y;
    logic [cov_pkg::ANG_W-1:0]       r_s0_z;
    cov_pkg::t_side                  r_s0_side;

    always_comb begin
        idx_c = (i_vertex_index > cov_pkg::IDX_W'(cov_pkg::LAST_INDEX))
              ? cov_pkg::IDX_W'(cov_pkg::LAST_INDEX) : i_vertex_index;
        n_s0_side.end_cap = idx_c < cov_pkg::IDX_W'(cov_pkg::CAP_VERTICES);
        n_s0_side.k       = n_s0_side.end_cap ? cov_pkg::K_W'(idx_c)
                          : cov_pkg::K_W'(idx_c - cov_pkg::IDX_W'(cov_pkg::CAP_VERTICES));
        n_s0_side.zero    = (r_end_dx == '0) && (r_end_dy == '0);
        n_s0_x = cov_pkg::XY_W'(r_end_dx) <<< cov_pkg::PRESCALE_SH;
        n_s0_y = cov_pkg::XY_W'(r_end_dy) <<< cov_pkg::PRESCALE_SH;
        n_s0_z = '0;
        if (r_end_dx[cov_pkg::COORD_W-1]) begin
            // turn the vector by half a turn into the right half plane
            n_s0_x = -n_s0_x;
            n_s0_y = -n_s0_y;
            n_s0_z = cov_pkg::HALF_TURN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (en) begin
            r_s0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_x    <= n_s0_x;
            r_s0_y    <= n_s0_y;
            r_s0_z    <= n_s0_z;
            r_s0_side <= n_s0_side;
        end
    end

    // Vectoring chain: direction angle theta
    logic                            w_vv [NS+1];
    logic signed [cov_pkg::XY_W-1:0] w_vx [NS+1];
    logic signed [cov_pkg::XY_W-1:0] w_vy [NS+1];
    logic [cov_pkg::ANG_W-1:0]       w_vz [NS+1];
    cov_pkg::t_side                  w_vs [NS+1];

    assign w_vv[0] = r_s0_valid;
    assign w_vx[0] = r_s0_x;
    assign w_vy[0] = r_s0_y;
    assign w_vz[0] = r_s0_z;
    assign w_vs[0] = r_s0_side;

    for (genvar g = 0; g < NS; g++) begin : g_vec
        cov_vec_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_step  (cov_pkg::STEP_W'(g)),
            .i_valid (w_vv[g]),
            .i_x     (w_vx[g]),
            .i_y     (w_vy[g]),
            .i_z     (w_vz[g]),
            .i_side  (w_vs[g]),
            .o_valid (w_vv[g+1]),
            .o_x     (w_vx[g+1]),
            .o_y     (w_vy[g+1]),
            .o_z     (w_vz[g+1]),
            .o_side  (w_vs[g+1])
        );
    end

    // Angle stage: vertex angle, fold into the right half plane, scaled radius
    logic [cov_pkg::ANG_W-1:0]       theta, ang_a, ang_q, ang_f;
    logic                            n_ang_flip;
    logic [cov_pkg::PROD_W-1:0]      n_ang_prod;

    logic                            r_ang_valid;
    logic                            r_ang_flip;
    logic signed [cov_pkg::RZ_W-1:0] r_ang_z;
    logic [cov_pkg::PROD_W-1:0]      r_ang_prod;
    cov_pkg::t_side                  r_ang_side;

    always_comb begin
        theta      = w_vs[NS].zero ? '0 : w_vz[NS];
        ang_a      = theta + cov_pkg::cap_step(w_vs[NS].k) - cov_pkg::QUARTER_TURN;
        ang_q      = ang_a + cov_pkg::QUARTER_TURN;
        n_ang_flip = ang_q[cov_pkg::ANG_W-1];
        ang_f      = n_ang_flip ? (ang_a ^ cov_pkg::HALF_TURN) : ang_a;
        n_ang_prod = cov_pkg::PROD_W'(r_line_width) * cov_pkg::PROD_W'(cov_pkg::INV_GAIN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ang_valid <= 1'b0;
        end else if (en) begin
            r_ang_valid <= w_vv[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ang_flip <= n_ang_flip;
            r_ang_z    <= cov_pkg::RZ_W'(signed'(ang_f));
            r_ang_prod <= n_ang_prod;
            r_ang_side <= w_vs[NS];
        end
    end

    // Rotation chain: cap offset (c, s)
    logic                            w_rv [NS+1];
    logic signed [cov_pkg::XY_W-1:0] w_rx [NS+1];
    logic signed [cov_pkg::XY_W-1:0] w_ry [NS+1];
    logic signed [cov_pkg::RZ_W-1:0] w_rz [NS+1];
    cov_pkg::t_side                  w_rs [NS+1];
    logic signed [cov_pkg::XY_W-1:0] rot_x0;

    assign rot_x0  = cov_pkg::XY_W'(r_ang_prod);
    assign w_rv[0] = r_ang_valid;
    assign w_rx[0] = r_ang_flip ? -rot_x0 : rot_x0;
    assign w_ry[0] = '0;
    assign w_rz[0] = r_ang_z;
    assign w_rs[0] = r_ang_side;

    for (genvar g = 0; g < NS; g++) begin : g_rot
        cov_rot_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_step  (cov_pkg::STEP_W'(g)),
            .i_valid (w_rv[g]),
            .i_x     (w_rx[g]),
            .i_y     (w_ry[g]),
            .i_z     (w_rz[g]),
            .i_side  (w_rs[g]),
            .o_valid (w_rv[g+1]),
            .o_x     (w_rx[g+1]),
            .o_y     (w_ry[g+1]),
            .o_z     (w_rz[g+1]),
            .o_side  (w_rs[g+1])
        );
    end

    // Rounding stage: drop the scale bits, round to nearest with ties up
    localparam logic signed [cov_pkg::XY_W-1:0] RND_HALF =
        cov_pkg::XY_W'(1) <<< (cov_pkg::OUT_SHIFT - 1);

    logic signed [cov_pkg::XY_W-1:0]  rnd_x, rnd_y;
    logic                             r_rnd_valid;
    logic                             r_rnd_end_cap;
    logic signed [cov_pkg::RND_W-1:0] r_rnd_c, r_rnd_s;

    assign rnd_x = (w_rx[NS] + RND_HALF) >>> cov_pkg::OUT_SHIFT;
    assign rnd_y = (w_ry[NS] + RND_HALF) >>> cov_pkg::OUT_SHIFT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rnd_valid <= 1'b0;
        end else if (en) begin
            r_rnd_valid <= w_rv[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rnd_c       <= cov_pkg::RND_W'(rnd_x);
            r_rnd_s       <= cov_pkg::RND_W'(rnd_y);
            r_rnd_end_cap <= w_rs[NS].end_cap;
        end
    end

    // Vertex assembly and saturation
    logic signed [cov_pkg::SUM_W-1:0]   sum_x, sum_y;
    logic signed [cov_pkg::COORD_W-1:0] fin_x, fin_y;

    always_comb begin
        if (r_rnd_end_cap) begin
            sum_x = cov_pkg::SUM_W'(r_end_dx) + cov_pkg::SUM_W'(cov_pkg::ONE)
                  + cov_pkg::SUM_W'(r_rnd_c);
            sum_y = cov_pkg::SUM_W'(r_end_dy) + cov_pkg::SUM_W'(r_rnd_s);
        end else begin
            sum_x = cov_pkg::SUM_W'(cov_pkg::ONE) - cov_pkg::SUM_W'(r_rnd_c);
            sum_y = -cov_pkg::SUM_W'(r_rnd_s);
        end
        fin_x = cov_pkg::sat16(sum_x);
        fin_y = cov_pkg::sat16(sum_y);
    end

    // Output register with skid entry
    logic                               r_out_valid;
    logic signed [cov_pkg::COORD_W-1:0] r_out_x, r_out_y;
    logic signed [cov_pkg::COORD_W-1:0] r_skid_x, r_skid_y;
    logic                               push, load_out, load_skid, pop_skid;

    assign push      = en && r_rnd_valid;
    assign load_out  = push && (!r_out_valid || i_ready);
    assign load_skid = push && r_out_valid && !i_ready;
    assign pop_skid  = r_skid_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (load_out || pop_skid) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (load_skid) begin
                r_skid_valid <= 1'b1;
            end else if (pop_skid) begin
                r_skid_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_x <= fin_x;
            r_out_y <= fin_y;
        end else if (pop_skid) begin
            r_out_x <= r_skid_x;
            r_out_y <= r_skid_y;
        end
        if (load_skid) begin
            r_skid_x <= fin_x;
            r_skid_y <= fin_y;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_vertex_x = r_out_x;
    assign o_vertex_y = r_out_y;

    // An occupied skid entry always sits behind a waiting output item
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid without a valid output item");

    // A finished item arriving at a stalled output lands in the skid entry
    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && r_out_valid && !i_ready) |=> r_skid_valid)
        else $error("item lost at stalled output");

    // An accepted item enters the input stage
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_s0_valid)
        else $error("accepted item missing from input stage");

    // The chain holds its contents while the skid entry is occupied
    a_chain_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_ready) |=> ($stable(r_rnd_valid) && $stable(r_rnd_c)
                                        && $stable(r_ang_z)))
        else $error("chain advanced while stalled");

endmodule

// ===== tb/tb_capsule_outline_vertex_core.sv =====
// Self-checking testbench for capsule_outline_vertex_core: predicts every outline vertex
// with its own CORDIC model and checks results in order. Depends on cov_pkg and the core.
`timescale 1ns / 100ps

module tb_capsule_outline_vertex_core;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_STALL     = 150;
    localparam int DRAIN_PAD      = 40;
    localparam int HALF_VERTS     = 15;
    localparam int LAST_VERTEX    = 29;
    localparam longint ONE_PX     = 16;
    localparam longint WIDTH_GAIN = 39797;

    // atan(2^-i), 2^32 units per turn
    localparam logic [0:15][31:0] ATAN_STEP = {
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D
    };

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
    } t_vertex;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n;
    logic                                i_cfg_wen;
    logic [cov_pkg::CFG_IDX_W-1:0]       i_cfg_idx;
    logic [cov_pkg::COORD_W-1:0]         i_cfg_wdata;
    logic                                i_valid;
    logic                                o_ready;
    logic [cov_pkg::IDX_W-1:0]           i_vertex_index;
    logic                                o_valid;
    logic                                i_ready = 1'b0;
    logic signed [cov_pkg::COORD_W-1:0]  o_vertex_x;
    logic signed [cov_pkg::COORD_W-1:0]  o_vertex_y;

    // Shadow copy of the geometry registers
    longint  cur_dx;
    longint  cur_dy;
    longint  cur_width;

    t_vertex pending_vertices[$];
    int      mismatches   = 0;
    int      idle_cycles  = 0;
    int      stall_left   = 0;
    bit      hold_off_req = 1'b0;
    bit      idle_on      = 1'b1;
    bit      offering     = 1'b0;

    capsule_outline_vertex_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wen      (i_cfg_wen),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_vertex_index (i_vertex_index),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_vertex_x     (o_vertex_x),
        .o_vertex_y     (o_vertex_y)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Vertex predictor
    // ---------------------------------------------------------------------

    // Direction of the segment by vectoring CORDIC; a zero-length segment points along +x.
    function automatic logic [31:0] segment_heading(input longint dx, input longint dy);
        longint      x;
        longint      y;
        longint      xs;
        longint      ys;
        logic [31:0] z;
        x = dx * 16384;
        y = dy * 16384;
        z = 32'd0;
        if (dx == 0 && dy == 0)
            return 32'd0;
        // Left half plane: turn the vector by half a turn first
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_STEP[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_STEP[i];
            end
        end
        return z;
    endfunction

    // Cap offset (r cos a, r sin a) by rotation CORDIC, rounded to Q11.4.
    function automatic void cap_offset(input logic [31:0] ang, input longint width,
                                       output longint c, output longint s);
        longint      x;
        longint      y;
        longint      z;
        longint      xs;
        longint      ys;
        logic [31:0] a;
        logic [31:0] shifted;
        a = ang;
        x = width * WIDTH_GAIN;
        y = 0;
        // Fold the back half of the circle onto the front half
        shifted = a + 32'h4000_0000;
        if (shifted[31]) begin
            x = -x;
            a = a - 32'h8000_0000;
        end
        z = longint'($signed(a));
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(ATAN_STEP[i]);
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(ATAN_STEP[i]);
            end
        end
        c = (x + 65536) >>> 17;
        s = (y + 65536) >>> 17;
    endfunction

    function automatic logic signed [15:0] clamp16(input longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic t_vertex outline_vertex(input logic [4:0] raw);
        int          idx;
        int          k;
        bit          end_cap;
        longint      step;
        longint      c;
        longint      s;
        logic [31:0] a;
        t_vertex     v;
        // Indices past the outline act as the last vertex
        idx     = (raw > LAST_VERTEX) ? LAST_VERTEX : int'(raw);
        end_cap = idx < HALF_VERTS;
        k       = end_cap ? idx : idx - HALF_VERTS;
        step    = (longint'(k) << 31) / (HALF_VERTS - 1);
        a       = segment_heading(cur_dx, cur_dy) + step[31:0] - 32'h4000_0000;
        cap_offset(a, cur_width, c, s);
        if (end_cap) begin
            v.x = clamp16(cur_dx + ONE_PX + c);
            v.y = clamp16(cur_dy + s);
        end else begin
            v.x = clamp16(ONE_PX - c);
            v.y = clamp16(-s);
        end
        return v;
    endfunction

    // ---------------------------------------------------------------------
    // Result side: receiver stalls, checking, watchdog
    // ---------------------------------------------------------------------

    // Drop ready in short random bursts while idling is on; honor one long hold-off on request.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_ready <= 1'b0;
        end else if (hold_off_req) begin
            hold_off_req = 1'b0;
            stall_left   = LONG_STALL - 1;
            i_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 3);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Compare each accepted vertex with the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_vertex want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_vertices.size() == 0) begin
                mismatches++;
                $display("%0t: vertex with nothing expected: x %0d y %0d",
                         $time, o_vertex_x, o_vertex_y);
            end else begin
                want = pending_vertices.pop_front();
                if (o_vertex_x !== want.x) begin
                    mismatches++;
                    $display("%0t: vertex_x expected %0d actual %0d",
                             $time, want.x, o_vertex_x);
                end
                if (o_vertex_y !== want.y) begin
                    mismatches++;
                    $display("%0t: vertex_y expected %0d actual %0d",
                             $time, want.y, o_vertex_y);
                end
            end
        end
    end

    // End the run if no item moves on either channel for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("capsule_outline_vertex_core: mismatch");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Shared sender tasks
    // ---------------------------------------------------------------------

    // Offer one index, with an optional gap first; record the prediction once accepted.
    task automatic send_vertex(input logic [4:0] idx);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            if (offering)
                i_valid <= 1'b0;
            offering = 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_vertex_index <= idx;
        offering = 1'b1;
        do
            @(posedge i_clk);
        while (!o_ready);
        pending_vertices.push_back(outline_vertex(idx));
    endtask

    // Stop offering; wait out the clock edge that drops valid, so the next raise of valid lands in a later step.
    task automatic end_burst();
        if (offering) begin
            i_valid <= 1'b0;
            offering = 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic wait_for_results();
        while (pending_vertices.size() != 0)
            @(posedge i_clk);
    endtask

    // Rewrite all three registers once the core has drained.
    task automatic set_geometry(input logic [15:0] dx, input logic [15:0] dy,
                                input logic [14:0] width);
        logic spare;
        spare = 1'($urandom_range(0, 1));
        end_burst();
        wait_for_results();
        repeat (4) @(posedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_idx   <= cov_pkg::CFG_END_DX;
        i_cfg_wdata <= dx;
        @(posedge i_clk);
        cur_dx = longint'($signed(dx));
        i_cfg_idx   <= cov_pkg::CFG_END_DY;
        i_cfg_wdata <= dy;
        @(posedge i_clk);
        cur_dy = longint'($signed(dy));
        // The top bit is outside line_width and must be ignored
        i_cfg_idx   <= cov_pkg::CFG_LINE_WIDTH;
        i_cfg_wdata <= {spare, width};
        @(posedge i_clk);
        cur_width = longint'(width);
        i_cfg_wen <= 1'b0;
    endtask

    function automatic logic [15:0] rand_coord();
        int pick;
        pick = $urandom_range(0, 5);
        case (pick)
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'($urandom_range(0, 400) - 200);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [14:0] rand_width();
        int pick;
        pick = $urandom_range(0, 4);
        case (pick)
            0:       return 15'h7FFF;
            1:       return 15'h0000;
            2:       return 15'($urandom_range(0, 96));
            default: return 15'($urandom);
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Reset geometry is a zero-length segment; also cover the out-of-range indices.
    task automatic test_zero_length_segment();
        send_vertex(5'd0);
        send_vertex(5'd7);
        send_vertex(5'd14);
        send_vertex(5'd15);
        send_vertex(5'd22);
        send_vertex(5'd29);
        send_vertex(5'd30);
        send_vertex(5'd31);
    endtask

    // Push coordinates past both ends of the 16-bit range.
    task automatic test_coordinate_saturation();
        set_geometry(16'h7FFF, 16'h8000, 15'h7FFF);
        send_vertex(5'd0);
        send_vertex(5'd7);
        send_vertex(5'd14);
        send_vertex(5'd15);
        send_vertex(5'd29);
        set_geometry(16'h8000, 16'h7FFF, 15'h7FFF);
        send_vertex(5'd0);
        send_vertex(5'd22);
    endtask

    // Segments along the axes, the left half plane and a zero width.
    task automatic test_axis_directions();
        set_geometry(16'($signed(-160)), 16'd0, 15'd48);
        send_vertex(5'd0);
        send_vertex(5'd7);
        send_vertex(5'd14);
        send_vertex(5'd21);
        set_geometry(16'd0, 16'($signed(-200)), 15'd0);
        send_vertex(5'd0);
        send_vertex(5'd29);
        set_geometry(16'd0, 16'd320, 15'd64);
        send_vertex(5'd7);
        send_vertex(5'd22);
    endtask

    // Many geometries; each phase walks whole outlines or picks indices at random.
    task automatic test_random_geometry();
        int          count;
        bit          walk;
        logic [4:0]  idx;
        repeat (20) begin
            idle_on = ($urandom_range(0, 3) != 0);
            set_geometry(rand_coord(), rand_coord(), rand_width());
            count = $urandom_range(40, 84);
            walk  = 1'($urandom_range(0, 1));
            idx   = 5'($urandom_range(0, LAST_VERTEX));
            for (int j = 0; j < count; j++) begin
                if (walk)
                    idx = (idx >= LAST_VERTEX) ? 5'd0 : idx + 5'd1;
                else if ($urandom_range(0, 7) == 0)
                    idx = 5'($urandom_range(30, 31));
                else
                    idx = 5'($urandom_range(0, LAST_VERTEX));
                send_vertex(idx);
            end
        end
    endtask

    // Hold the receiver off long enough for the pipeline and skid entry to fill.
    task automatic test_output_backpressure();
        idle_on = 1'b1;
        set_geometry(rand_coord(), rand_coord(), rand_width());
        idle_on      = 1'b0;
        hold_off_req = 1'b1;
        repeat (100)
            send_vertex(5'($urandom_range(0, 31)));
    endtask

    // Let the core drain completely mid-geometry, then resume.
    task automatic test_pause_and_resume();
        idle_on = 1'b1;
        set_geometry(rand_coord(), rand_coord(), rand_width());
        repeat (20)
            send_vertex(5'($urandom_range(0, 31)));
        end_burst();
        wait_for_results();
        repeat (20)
            send_vertex(5'($urandom_range(0, 31)));
    endtask

    // Back-to-back outlines at full rate, no idling on either side.
    task automatic test_steady_stream();
        idle_on = 1'b1;
        set_geometry(rand_coord(), rand_coord(), rand_width());
        idle_on = 1'b0;
        for (int j = 0; j < 150; j++)
            send_vertex(5'(j % 30));
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_cfg_wen      <= 1'b0;
        i_cfg_idx      <= cov_pkg::CFG_END_DX;
        i_cfg_wdata    <= '0;
        i_valid        <= 1'b0;
        i_vertex_index <= '0;
        cur_dx    = 0;
        cur_dy    = 0;
        cur_width = 16;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_length_segment();
        test_coordinate_saturation();
        test_axis_directions();
        test_random_geometry();
        test_output_backpressure();
        test_pause_and_resume();
        test_steady_stream();

        // Drain, then watch a little longer for stray results
        end_burst();
        wait_for_results();
        repeat (DRAIN_PAD) @(posedge i_clk);
        if (mismatches == 0 && pending_vertices.size() == 0)
            $display("capsule_outline_vertex_core: match");
        else
            $display("capsule_outline_vertex_core: mismatch");
        $finish;
    end

endmodule
